// ===== design/ptb_pkg.sv =====
package ptb_pkg;

    // bank geometry
    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = 32;

    // operation codes
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ARM  = 2'd1,
        OP_POLL = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // per-timer state codes
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_RUNNING = 2'd1,
        ST_EXPIRED = 2'd2
    } t_tstate;

    // input item
    typedef struct packed {
        t_op         opcode;
        logic [2:0]  which_timer;
        logic [31:0] period_ticks;
    } t_in;

    // result item
    typedef struct packed {
        logic       fired;
        logic [2:0] fired_index;
        logic       last;
    } t_res;

    // one memory word: running count and period
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] period;
    } t_entry;

    // sequencer to datapath controls
    typedef struct packed {
        logic             tick_rd;
        logic             poll_chk;
        logic             empty;
        logic [IDX_W-1:0] idx;
    } t_seq_ctl;

    // requests into the count memory
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             arm;
        logic [IDX_W-1:0] arm_addr;
        logic [CNT_W-1:0] arm_period;
    } t_mem_cmd;

    // tick write-back report
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_upd;

endpackage

// ===== design/ptb_mem.sv =====
module ptb_mem
    import ptb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_cmd i_cmd,
    output t_upd     o_upd
);

    t_entry           r_mem [NUM_TIMERS];
    t_entry           r_rd_data;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    logic [CNT_W-1:0] n_count;
    logic             hit;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    // registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= i_cmd.rd_addr;
        r_rd_data <= r_mem[i_cmd.rd_addr];
    end

    // advance the count and compare against the period
    assign n_count = r_rd_data.count + {{(CNT_W-1){1'b0}}, 1'b1};
    assign hit     = (n_count == r_rd_data.period);

    // single write port: arm or tick write-back, never both at once
    always_comb begin
        if (i_cmd.arm) begin
            wr_en          = 1'b1;
            wr_addr        = i_cmd.arm_addr;
            wr_data.count  = '0;
            wr_data.period = i_cmd.arm_period;
        end else begin
            wr_en          = r_rd_vld;
            wr_addr        = r_rd_idx;
            wr_data.count  = hit ? '0 : n_count;
            wr_data.period = r_rd_data.period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    assign o_upd.valid = r_rd_vld;
    assign o_upd.hit   = hit;
    assign o_upd.idx   = r_rd_idx;

endmodule

// ===== design/ptb_seq.sv =====
module ptb_seq
    import ptb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_op      i_op,
    input  logic     i_any_exp,
    output logic     o_busy,
    output t_seq_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_DRAIN,
        S_POLL,
        S_EMPTY
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;

    // sweep sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_accept) begin
                        case (i_op)
                            OP_TICK: r_state <= S_TICK;
                            OP_POLL: r_state <= i_any_exp ? S_POLL : S_EMPTY;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_TICK: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_POLL: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN: r_state <= S_IDLE;
                S_EMPTY: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_ctl.tick_rd  = (r_state == S_TICK);
    assign o_ctl.poll_chk = (r_state == S_POLL);
    assign o_ctl.empty    = (r_state == S_EMPTY);
    assign o_ctl.idx      = r_idx;

endmodule

// ===== design/periodic_timer_bank_unit.sv =====
// channel   ports                     handshake
// command   start, i_item (t_in)      taken when start is high and busy is low
// result    o_valid, o_res (t_res)    one-cycle strobe, cannot be held off
//
// tick: sweeps every timer, reading memory only for non-idle ones, then a drain state for the last write-back
// poll: one timer state checked per cycle across every timer; if none expired, a single empty result instead
// arm, unused opcode and out-of-range arm: taken while busy stays low
// results trail the cycle that finds them by one register stage
// synchronous active-low reset puts every timer idle; counts and periods stay undefined
module periodic_timer_bank_unit
    import ptb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_res o_res
);

    t_tstate             r_tstate [NUM_TIMERS];
    logic                r_valid;
    t_res                r_res;

    logic                accept;
    logic                arm_ok;
    logic [IDX_W-1:0]    arm_idx;
    logic [NUM_TIMERS-1:0] exp_mask;
    logic [NUM_TIMERS-1:0] above_mask;
    logic                any_exp;
    logic                poll_hit;
    t_seq_ctl            ctl;
    t_mem_cmd            mem_cmd;
    t_upd                upd;

    assign accept  = start && !busy;
    assign arm_ok  = accept && (i_item.opcode == OP_ARM)
                     && (int'(i_item.which_timer) < NUM_TIMERS);
    assign arm_idx = IDX_W'(i_item.which_timer);

    // expired timers and those above the poll position
    always_comb begin
        for (int j = 0; j < NUM_TIMERS; j++) begin
            exp_mask[j]   = (r_tstate[j] == ST_EXPIRED);
            above_mask[j] = exp_mask[j] && (j > int'(ctl.idx));
        end
    end

    assign any_exp  = |exp_mask;
    assign poll_hit = ctl.poll_chk && exp_mask[ctl.idx];

    ptb_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_op      (i_item.opcode),
        .i_any_exp (any_exp),
        .o_busy    (busy),
        .o_ctl     (ctl)
    );

    // memory requests: skip idle timers during a tick sweep
    assign mem_cmd.rd_en      = ctl.tick_rd && (r_tstate[ctl.idx] != ST_IDLE);
    assign mem_cmd.rd_addr    = ctl.idx;
    assign mem_cmd.arm        = arm_ok;
    assign mem_cmd.arm_addr   = arm_idx;
    assign mem_cmd.arm_period = i_item.period_ticks;

    ptb_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mem_cmd),
        .o_upd   (upd)
    );

    // timer state flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_TIMERS; j++) begin
                r_tstate[j] <= ST_IDLE;
            end
        end else begin
            if (arm_ok) begin
                r_tstate[arm_idx] <= ST_RUNNING;
            end
            if (upd.valid && upd.hit) begin
                r_tstate[upd.idx] <= ST_EXPIRED;
            end
            if (poll_hit) begin
                r_tstate[ctl.idx] <= ST_RUNNING;
            end
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= poll_hit || ctl.empty;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (ctl.empty) begin
            r_res.fired       <= 1'b0;
            r_res.fired_index <= '0;
            r_res.last        <= 1'b1;
        end else begin
            r_res.fired       <= 1'b1;
            r_res.fired_index <= 3'(ctl.idx);
            r_res.last        <= ~(|above_mask);
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef ASSERT_OFF
    // a tick sweep holds off the next item
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.opcode == OP_TICK)) |=> busy)
        else $error("tick accepted without entering sweep");

    // an empty poll result is always the final one
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.fired) |-> o_res.last)
        else $error("empty poll result not marked last");

    // a reported timer has been returned to running
    a_fired_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.fired) |-> (r_tstate[IDX_W'(o_res.fired_index)] == ST_RUNNING))
        else $error("reported timer not running");

    // arm writes never collide with a tick write-back
    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        arm_ok |-> !upd.valid)
        else $error("arm collides with tick write-back");
`endif

endmodule

// ===== tb/sv/tb_periodic_timer_bank_unit.sv =====
module tb_periodic_timer_bank_unit
    import ptb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 430;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 4 * NUM_TIMERS;

    // tracks every timer and the expiry reports that polls must produce
    class expiry_tracker;
        t_tstate     tstate  [NUM_TIMERS];
        logic [31:0] count   [NUM_TIMERS];
        logic [31:0] period  [NUM_TIMERS];
        t_res        pending_reports[$];
        int          errors;

        function new();
            errors = 0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                tstate[i] = ST_IDLE;
                count[i]  = '0;
                period[i] = '0;
            end
        endfunction

        // advance the predicted bank by one accepted item
        function void take_command(t_in it);
            logic [31:0] nxt;
            int          n_exp;
            int          k;
            t_res        r;
            case (it.opcode)
                OP_TICK: begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (tstate[i] != ST_IDLE) begin
                            nxt = count[i] + 32'd1;
                            if (nxt == period[i]) begin
                                count[i]  = '0;
                                tstate[i] = ST_EXPIRED;
                            end else begin
                                count[i] = nxt;
                            end
                        end
                    end
                end
                OP_ARM: begin
                    if (int'(it.which_timer) < NUM_TIMERS) begin
                        count[it.which_timer]  = '0;
                        period[it.which_timer] = it.period_ticks;
                        tstate[it.which_timer] = ST_RUNNING;
                    end
                end
                OP_POLL: begin
                    n_exp = 0;
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (tstate[i] == ST_EXPIRED) n_exp++;
                    end
                    if (n_exp == 0) begin
                        r.fired       = 1'b0;
                        r.fired_index = '0;
                        r.last        = 1'b1;
                        pending_reports.push_back(r);
                    end else begin
                        k = 0;
                        for (int i = 0; i < NUM_TIMERS; i++) begin
                            if (tstate[i] == ST_EXPIRED) begin
                                tstate[i]     = ST_RUNNING;
                                r.fired       = 1'b1;
                                r.fired_index = 3'(i);
                                r.last        = (k == n_exp - 1);
                                pending_reports.push_back(r);
                                k++;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // compare one strobed result with the oldest predicted report
        function void match_report(t_res got);
            t_res want;
            if (pending_reports.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %b/%0d/%b",
                         $time, got.fired, got.fired_index, got.last);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            if (got.fired !== want.fired) begin
                $display("%0t fired mismatch: expected %b, actual %b",
                         $time, want.fired, got.fired);
                errors++;
            end
            if (got.fired_index !== want.fired_index) begin
                $display("%0t fired_index mismatch: expected %0d, actual %0d",
                         $time, want.fired_index, got.fired_index);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t last mismatch: expected %b, actual %b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_valid;
    t_res o_res;

    expiry_tracker tracker = new();
    int unsigned   cycles = 0;

    periodic_timer_bank_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run-time guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d reports outstanding", $time,
                     tracker.pending_reports.size());
            $display("FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) tracker.match_report(o_res);
    end

    function automatic t_in make_item(t_op op, logic [2:0] which, logic [31:0] per);
        t_in it;
        it.opcode       = op;
        it.which_timer  = which;
        it.period_ticks = per;
        return it;
    endfunction

    // present one item after an idle gap and hold it until taken
    task automatic send_item(input t_in it, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        tracker.take_command(it);
    endtask

    // hold the command side off until every predicted report has come
    task automatic wait_all_reported();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_reports.size() != 0);
    endtask

    function automatic int draw_gap(bit burst);
        return burst ? 0 : int'($urandom_range(0, 10));
    endfunction

    // stimulus
    initial begin
        int   sent;
        int   sel;
        bit   burst;
        bit   paused;
        t_op  op;
        logic [31:0] per;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty poll, tick with nothing armed, unused opcode
        send_item(make_item(OP_POLL, 3'd0, 32'd0), 0);
        send_item(make_item(OP_TICK, 3'd5, 32'hFFFF_FFFF), 1);
        send_item(make_item(OP_NONE, 3'd7, 32'hFFFF_FFFF), 0);
        // period extremes, including the zero period that only matches on wrap
        send_item(make_item(OP_ARM, 3'd0, 32'd1), 0);
        send_item(make_item(OP_ARM, 3'd7, 32'hFFFF_FFFF), 2);
        send_item(make_item(OP_ARM, 3'd3, 32'd0), 0);
        send_item(make_item(OP_TICK, 3'd0, 32'd0), 0);
        send_item(make_item(OP_POLL, 3'd0, 32'd0), 3);
        for (int i = 1; i <= 6; i++) begin
            if (i != 3) send_item(make_item(OP_ARM, 3'(i), 32'd1), i % 2);
        end
        send_item(make_item(OP_TICK, 3'd0, 32'd0), 0);
        // re-arm the two slow timers so that every timer expires at once
        send_item(make_item(OP_ARM, 3'd3, 32'd1), 0);
        send_item(make_item(OP_ARM, 3'd7, 32'd1), 0);
        send_item(make_item(OP_TICK, 3'd0, 32'd0), 0);
        send_item(make_item(OP_POLL, 3'd0, 32'd0), 0);
        send_item(make_item(OP_ARM, 3'd5, 32'hAAAA_AAAA), 1);
        send_item(make_item(OP_TICK, 3'd0, 32'd0), 0);
        // re-arming an expired timer makes it running with a cleared count
        send_item(make_item(OP_ARM, 3'd2, 32'h5555_5555), 0);
        send_item(make_item(OP_POLL, 3'd0, 32'd0), 0);
        send_item(make_item(OP_TICK, 3'd0, 32'd0), 4);
        send_item(make_item(OP_POLL, 3'd0, 32'd0), 0);

        // random: mostly small periods so timers keep expiring
        sent   = 0;
        burst  = 1'b0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            if (!paused && sent == RANDOM_ITEMS / 2) begin
                wait_all_reported();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 40)      op = OP_TICK;
            else if (sel < 62) op = OP_ARM;
            else if (sel < 90) op = OP_POLL;
            else               op = OP_NONE;
            if (op == OP_ARM) begin
                case ($urandom_range(0, 9))
                    0:       per = $urandom;
                    1:       per = 32'd0;
                    default: per = $urandom_range(1, 12);
                endcase
            end else begin
                per = $urandom;
            end
            send_item(make_item(op, 3'($urandom_range(0, 7)), per), draw_gap(burst));
            sent++;
        end

        // drain and let any stray strobes show up
        wait_all_reported();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.pending_reports.size() != 0) begin
            $display("%0t missing results: expected %0d more, actual 0", $time,
                     tracker.pending_reports.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ptb_pkg.sv
design/ptb_mem.sv
design/ptb_seq.sv
design/periodic_timer_bank_unit.sv
tb/sv/tb_periodic_timer_bank_unit.sv
